[src/postfix_stack_evaluator_unit_defines.svh]
// Assertion helpers for the postfix evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define PSE_ASSERT_SAME(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define PSE_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error(msg);

`endif

[src/pse_pkg.sv]
`default_nettype none

package pse_pkg;

    localparam int DATA_W = 32;
    localparam int SYM_W = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int DIV_STEP_W = $clog2(DATA_W);

    // Expression characters
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_TIMES = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_END   = 8'h24;
    localparam logic [SYM_W-1:0] SYM_A     = 8'h61;
    localparam logic [SYM_W-1:0] SYM_B     = 8'h62;
    localparam logic [SYM_W-1:0] SYM_C     = 8'h63;
    localparam logic [SYM_W-1:0] SYM_D     = 8'h64;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_INTERMEDIATE = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FINAL        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DIVZERO      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_OF_A = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_OF_B = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_OF_C = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_OF_D = 2'd3;

    localparam logic [DATA_W-1:0] RESET_VALUE_OF_A = 32'd5;
    localparam logic [DATA_W-1:0] RESET_VALUE_OF_B = 32'd7;
    localparam logic [DATA_W-1:0] RESET_VALUE_OF_C = 32'd2;
    localparam logic [DATA_W-1:0] RESET_VALUE_OF_D = 32'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

[src/pse_stack_mem.sv]
`default_nettype none

module pse_stack_mem #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [pse_pkg::DATA_W-1:0] wdata,
    input  wire logic [AW-1:0]              raddr0,
    input  wire logic [AW-1:0]              raddr1,
    output logic      [pse_pkg::DATA_W-1:0] rdata0,
    output logic      [pse_pkg::DATA_W-1:0] rdata1
);

    logic [pse_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

[src/pse_div.sv]
`default_nettype none

module pse_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pse_pkg::div_req_t req,
    output pse_pkg::div_rsp_t      rsp
);

    localparam int W = pse_pkg::DATA_W;
    localparam int SW = pse_pkg::DIV_STEP_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.num[W-1] ? (~req.num + W'(1)) : req.num;
            den_next  = req.den[W-1] ? (~req.den + W'(1)) : req.den;
            neg_next  = req.num[W-1] ^ req.den[W-1];
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            step_next = step_reg + SW'(1);
            if (step_reg == SW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? (~quo_reg + W'(1)) : quo_reg;

endmodule

`default_nettype wire

[src/postfix_stack_evaluator_unit.sv]
// Postfix evaluator: one ASCII character per input word, values on a stack of
// STACK_DEPTH 32-bit entries held in a synchronous RAM. Letters a to d push
// their configured value straight into the RAM; unknown characters are
// dropped. + - * and $ pass through RAM read, compute and result load, and
// / waits on the 32-step restoring divider before its result load. One word
// is in flight at a time; a result waits in the output register while the
// next word is taken, and stalls the block only when a second result is
// ready before the first has been taken. Underflow, overflow and divide by
// zero return status codes with a zero value and leave the stack unchanged;
// $ returns the top entry and empties the stack.

`default_nettype none
`include "postfix_stack_evaluator_unit_defines.svh"

module postfix_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pse_pkg::SYM_W-1:0]        s_symbol,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [pse_pkg::DATA_W-1:0]     m_result_value,
    output logic      [pse_pkg::STATUS_W-1:0]     m_status,
    input  wire logic                             cfg_we,
    input  wire logic [pse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pse_pkg::DATA_W-1:0]       cfg_wdata
);

    localparam int W = pse_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    pse_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [pse_pkg::SYM_W-1:0]    sym_reg, sym_next;
    logic [W-1:0]                 res_reg, res_next;
    logic [pse_pkg::STATUS_W-1:0] pst_reg, pst_next;
    logic                         wb_reg, wb_next;
    logic                         clr_reg, clr_next;

    logic                         m_valid_reg;
    logic [W-1:0]                 m_value_reg;
    logic [pse_pkg::STATUS_W-1:0] m_status_reg;
    logic                         out_load;

    logic [W-1:0] val_a_reg, val_b_reg, val_c_reg, val_d_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;
    logic [W-1:0]  rd_top, rd_second;
    logic [CW-1:0] count_m1, count_m2;

    pse_pkg::div_req_t div_req;
    pse_pkg::div_rsp_t div_rsp;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    pse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (count_m1[AW-1:0]),
        .raddr1 (count_m2[AW-1:0]),
        .rdata0 (rd_top),
        .rdata1 (rd_second)
    );

    pse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == pse_pkg::ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sym_next    = sym_reg;
        res_next    = res_reg;
        pst_next    = pst_reg;
        wb_next     = wb_reg;
        clr_next    = clr_reg;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = val_a_reg;
        out_load    = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = rd_second;
        div_req.den   = rd_top;
        case (state_reg)
            pse_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sym_next = s_symbol;
                    case (s_symbol)
                        pse_pkg::SYM_A, pse_pkg::SYM_B, pse_pkg::SYM_C, pse_pkg::SYM_D: begin
                            if (count_reg >= CW'(STACK_DEPTH)) begin
                                res_next   = '0;
                                pst_next   = pse_pkg::STATUS_OVERFLOW;
                                wb_next    = 1'b0;
                                clr_next   = 1'b0;
                                state_next = pse_pkg::ST_EMIT;
                            end else begin
                                mem_we = 1'b1;
                                case (s_symbol)
                                    pse_pkg::SYM_B: mem_wdata = val_b_reg;
                                    pse_pkg::SYM_C: mem_wdata = val_c_reg;
                                    pse_pkg::SYM_D: mem_wdata = val_d_reg;
                                    default:        mem_wdata = val_a_reg;
                                endcase
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pse_pkg::SYM_PLUS, pse_pkg::SYM_MINUS, pse_pkg::SYM_TIMES,
                        pse_pkg::SYM_DIV: begin
                            if (count_reg < CW'(2)) begin
                                res_next   = '0;
                                pst_next   = pse_pkg::STATUS_UNDERFLOW;
                                wb_next    = 1'b0;
                                clr_next   = 1'b0;
                                state_next = pse_pkg::ST_EMIT;
                            end else begin
                                state_next = pse_pkg::ST_READ;
                            end
                        end
                        pse_pkg::SYM_END: begin
                            if (count_reg == '0) begin
                                res_next   = '0;
                                pst_next   = pse_pkg::STATUS_UNDERFLOW;
                                wb_next    = 1'b0;
                                clr_next   = 1'b0;
                                state_next = pse_pkg::ST_EMIT;
                            end else begin
                                state_next = pse_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pse_pkg::ST_READ: begin
                // stack top and the entry below are now out of the RAM
                wb_next    = 1'b1;
                clr_next   = 1'b0;
                pst_next   = pse_pkg::STATUS_INTERMEDIATE;
                state_next = pse_pkg::ST_EMIT;
                case (sym_reg)
                    pse_pkg::SYM_PLUS:  res_next = rd_second + rd_top;
                    pse_pkg::SYM_MINUS: res_next = rd_second - rd_top;
                    pse_pkg::SYM_TIMES: res_next = W'(rd_second * rd_top);
                    pse_pkg::SYM_DIV: begin
                        if (rd_top == '0) begin
                            res_next = '0;
                            pst_next = pse_pkg::STATUS_DIVZERO;
                            wb_next  = 1'b0;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = pse_pkg::ST_DIV_WAIT;
                        end
                    end
                    default: begin
                        res_next = rd_top;
                        pst_next = pse_pkg::STATUS_FINAL;
                        wb_next  = 1'b0;
                        clr_next = 1'b1;
                    end
                endcase
            end
            pse_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.quo;
                    state_next = pse_pkg::ST_EMIT;
                end
            end
            pse_pkg::ST_EMIT: begin
                // hold until the output register is free, then commit the stack update
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pse_pkg::ST_IDLE;
                    if (wb_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_m2[AW-1:0];
                        mem_wdata  = res_reg;
                        count_next = count_m1;
                    end
                    if (clr_reg) begin
                        count_next = '0;
                    end
                end
            end
            default: begin
                state_next = pse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pse_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
        res_reg <= res_next;
        pst_reg <= pst_next;
        wb_reg  <= wb_next;
        clr_reg <= clr_next;
        if (out_load) begin
            m_value_reg  <= res_reg;
            m_status_reg <= pst_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_a_reg <= pse_pkg::RESET_VALUE_OF_A;
            val_b_reg <= pse_pkg::RESET_VALUE_OF_B;
            val_c_reg <= pse_pkg::RESET_VALUE_OF_C;
            val_d_reg <= pse_pkg::RESET_VALUE_OF_D;
        end else if (cfg_we) begin
            case (cfg_addr)
                pse_pkg::CFG_VALUE_OF_A: val_a_reg <= cfg_wdata;
                pse_pkg::CFG_VALUE_OF_B: val_b_reg <= cfg_wdata;
                pse_pkg::CFG_VALUE_OF_C: val_c_reg <= cfg_wdata;
                pse_pkg::CFG_VALUE_OF_D: val_d_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status       = m_status_reg;

    `PSE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count above depth")
    `PSE_ASSERT_SAME(a_div_done_state, aclk, aresetn, div_rsp.done, state_reg == pse_pkg::ST_DIV_WAIT, "divider finished outside wait state")
    `PSE_ASSERT_NEXT(a_final_clears, aclk, aresetn, out_load && clr_reg, count_reg == '0, "final result left stack entries")
    `PSE_ASSERT_NEXT(a_load_valid, aclk, aresetn, out_load, m_valid && m_status == $past(pst_reg), "result load lost")

endmodule

`default_nettype wire
